// ===== hdl/ordered_array_insert_remove_unit_defines.svh =====
// Assertion macros for the ordered array insert/remove unit.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define OAIR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define OAIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/oair_pkg.sv =====
// Shared types and constants for the ordered array insert/remove unit.
// No dependencies; imported by the top level, the datapath and the controller.
package oair_pkg;

   // Default sizes
   localparam int OAIR_DEPTH  = 64;
   localparam int OAIR_ELEM_W = 32;

   // Port widths
   localparam int REQ_TDATA_W = 40;  // position(7) + item_value(32), padded
   localparam int RSP_TDATA_W = 40;  // item_out(32) + count_after(7), padded
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register map (word index)
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [6:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_POP    = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // Read address select relative to the walk pointer
   typedef enum logic [1:0] {
      RD_PREV = 2'd0,
      RD_HERE = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_UP_RD,
      S_UP_WR,
      S_WR_NEW,
      S_RM_RD,
      S_RM_CAP,
      S_DN_RD,
      S_DN_WR,
      S_RM_END,
      S_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       chk_load;
      logic       ptr_load_count;
      logic       ptr_load_at;
      logic       ptr_dec;
      logic       ptr_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic       cap_removed;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      status_type status;
      logic       is_add;
      logic       cnt_eq_at;
      logic       ptr_prev_eq_at;
      logic       ptr_at_end;
      logic       ptr_next_at_end;
      logic       rsp_free;
   } sts_type;

endpackage

// ===== hdl/ordered_array_insert_remove_unit.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: req_type; tdata: position, item_value
// rsp       out  rsp_tvalid/rsp_tready  tuser: status;   tdata: item_out, count_after
// csr       in   psel/penable/pwrite    capacity_limit at byte address 0
//
// One request at a time through a single-port-read, single-port-write entry RAM.
// A failed request goes from check to result. Append or insert at p moves entries
// p..n-1 up; remove at p (pop: p = n-1) moves later ones down, and each moved
// entry costs one RAM read and one RAM write. Synchronous reset clears the count,
// the FSM and capacity_limit (to 64). A stalled result holds in the output
// register; the next request is accepted meanwhile and waits only at its end.
`include "ordered_array_insert_remove_unit_defines.svh"
module ordered_array_insert_remove_unit import oair_pkg::*; #(
   parameter int DEPTH         = OAIR_DEPTH,
   parameter int ELEMENT_WIDTH = OAIR_ELEM_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [6:0] position, [38:7] item_value
   input  logic [1:0]             req_tuser,   // [1:0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] item_out, [38:32] count_after
   output logic [1:0]             rsp_tuser,   // [1:0] status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [6:0]  capacity_ff;
   logic        csr_sel_cap;
   cmd_type     cmd;
   sts_type     sts;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_item;
   logic [6:0]  rsp_count;

   // Configuration register
   assign csr_pready  = 1'b1;
   assign csr_sel_cap = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_cap) begin
         capacity_ff <= csr_pwdata[6:0];
      end
   end

   assign csr_prdata = csr_sel_cap ? CSR_DATA_W'(capacity_ff) : '0;

   oair_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   oair_dpath #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_tuser),
      .position       (req_tdata[6:0]),
      .item_value     (req_tdata[38:7]),
      .capacity_limit (capacity_ff),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_item       (rsp_item),
      .rsp_count      (rsp_count)
   );

   // Result word packing
   assign rsp_tdata = {1'b0, rsp_count, rsp_item};
   assign rsp_tuser = rsp_status;

   // Checks
   `OAIR_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `OAIR_ASSERT_IMPL(a_fail_no_item, rsp_tvalid && (rsp_tuser != STAT_OK), rsp_tdata[31:0] == '0, "item on failed request")
   `OAIR_ASSERT_IMPL(a_idle_no_ram, req_tready, !cmd.wr_en && !cmd.rd_en, "RAM access while idle")
   `OAIR_ASSERT_IMPL(a_no_overwrite, cmd.rsp_load, sts.rsp_free, "result overwritten")

endmodule

// ===== hdl/oair_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oair_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/oair_dpath.sv =====
// Datapath: request registers, entry count, walk pointer, entry RAM, result register.
// Depends on oair_pkg and oair_ram.
module oair_dpath import oair_pkg::*; #(
   parameter int DEPTH         = OAIR_DEPTH,
   parameter int ELEMENT_WIDTH = OAIR_ELEM_W
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_type,
   input  logic [6:0]  position,
   input  logic [31:0] item_value,
   input  logic [6:0]  capacity_limit,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_item,
   output logic [6:0]  rsp_count
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int WW  = ((CW > 7) ? CW : 7) + 1;
   localparam int ORW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

   kind_type               kind_ff;
   logic [6:0]             pos_ff;
   logic [ELEMENT_WIDTH-1:0] val_ff;
   logic [CW-1:0]          cnt_ff;
   logic [AW-1:0]          ptr_ff;
   logic [ELEMENT_WIDTH-1:0] removed_ff;
   status_type             stat_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [31:0]            rsp_item_ff;
   logic [6:0]             rsp_count_ff;

   logic [WW-1:0]          cnt_w;
   logic [WW-1:0]          pos_w;
   logic [WW-1:0]          lim_w;
   logic [WW-1:0]          at_w;
   logic [WW-1:0]          ptr_w;
   status_type             status;
   logic [ORW-1:0]         val_ext;
   logic [ORW-1:0]         removed_ext;
   logic [AW-1:0]          rd_addr;
   logic [ELEMENT_WIDTH-1:0] wr_data;
   logic [ELEMENT_WIDTH-1:0] rd_data;

   assign cnt_w = WW'(cnt_ff);
   assign pos_w = WW'(pos_ff);
   assign ptr_w = WW'(ptr_ff);
   assign lim_w = (WW'(capacity_limit) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(capacity_limit);
   assign val_ext     = ORW'(item_value);
   assign removed_ext = ORW'(removed_ff);

   // Target index of the request
   always_comb begin
      case (kind_ff)
         KIND_APPEND: at_w = cnt_w;
         KIND_POP:    at_w = cnt_w - WW'(1);
         default:     at_w = pos_w;
      endcase
   end

   // Request check: full test comes before the range test
   always_comb begin
      case (kind_ff)
         KIND_APPEND, KIND_INSERT: begin
            if (cnt_w >= lim_w) begin
               status = STAT_FULL;
            end else if (at_w > cnt_w) begin
               status = STAT_RANGE;
            end else begin
               status = STAT_OK;
            end
         end
         KIND_POP: begin
            status = (cnt_w == '0) ? STAT_EMPTY : STAT_OK;
         end
         default: begin
            status = (pos_w >= cnt_w) ? STAT_RANGE : STAT_OK;
         end
      endcase
   end

   // Status back to the controller
   always_comb begin
      sts.status          = status;
      sts.is_add          = (kind_ff == KIND_APPEND) || (kind_ff == KIND_INSERT);
      sts.cnt_eq_at       = (at_w == cnt_w);
      sts.ptr_prev_eq_at  = ((ptr_w - WW'(1)) == at_w);
      sts.ptr_at_end      = ((ptr_w + WW'(1)) >= cnt_w);
      sts.ptr_next_at_end = ((ptr_w + WW'(2)) >= cnt_w);
      sts.rsp_free        = !rsp_valid_ff || rsp_tready;
   end

   // Read address around the walk pointer
   always_comb begin
      case (cmd.rd_sel)
         RD_PREV: rd_addr = ptr_ff - AW'(1);
         RD_HERE: rd_addr = ptr_ff;
         RD_NEXT: rd_addr = ptr_ff + AW'(1);
         default: rd_addr = ptr_ff;
      endcase
   end

   assign wr_data = cmd.wr_new ? val_ff : rd_data;

   oair_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request payload and removed word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= kind_type'(req_type);
         pos_ff     <= position;
         val_ff     <= val_ext[ELEMENT_WIDTH-1:0];
         removed_ff <= '0;
      end else if (cmd.cap_removed) begin
         removed_ff <= rd_data;
      end
   end

   // Request verdict, held until the result is loaded
   always_ff @(posedge clock) begin
      if (cmd.chk_load) begin
         stat_ff <= status;
      end
   end

   // Walk pointer
   always_ff @(posedge clock) begin
      if (cmd.ptr_load_count) begin
         ptr_ff <= cnt_w[AW-1:0];
      end else if (cmd.ptr_load_at) begin
         ptr_ff <= at_w[AW-1:0];
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - AW'(1);
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + AW'(1);
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_item_ff   <= removed_ext[31:0];
         rsp_count_ff  <= cnt_w[6:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== hdl/oair_ctrl.sv =====
// Controller state machine: sequences checks, shifts, reads and the result.
// Depends on oair_pkg.
module oair_ctrl import oair_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_HERE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // verdict is taken before the count moves
            cmd.chk_load = 1'b1;
            if (sts.status != STAT_OK) begin
               state_in = S_DONE;
            end else if (sts.is_add) begin
               cmd.ptr_load_count = 1'b1;
               state_in = sts.cnt_eq_at ? S_WR_NEW : S_UP_RD;
            end else begin
               cmd.ptr_load_at = 1'b1;
               state_in        = S_RM_RD;
            end
         end
         // Shift up: entry ptr-1 moves to ptr
         S_UP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV;
            state_in   = S_UP_WR;
         end
         S_UP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_in    = sts.ptr_prev_eq_at ? S_WR_NEW : S_UP_RD;
         end
         S_WR_NEW: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         // Remove: fetch the target, then shift later entries down
         S_RM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HERE;
            state_in   = S_RM_CAP;
         end
         S_RM_CAP: begin
            cmd.cap_removed = 1'b1;
            state_in        = sts.ptr_at_end ? S_RM_END : S_DN_RD;
         end
         S_DN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_in   = S_DN_WR;
         end
         S_DN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = sts.ptr_next_at_end ? S_RM_END : S_DN_RD;
         end
         S_RM_END: begin
            cmd.cnt_dec = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== bench/ordered_array_insert_remove_unit_checker.sv =====
// Checker for the ordered array insert/remove unit: watches the request,
// response and register ports, predicts every response word and compares.
// Depends on oair_pkg for the request kinds, status codes and port widths.
`timescale 1ns / 100ps

module ordered_array_insert_remove_unit_checker import oair_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [6:0] position, [38:7] item_value
   input  logic [1:0]             req_tuser,   // [1:0] req_type
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] item_out, [38:32] count_after
   input  logic [1:0]             rsp_tuser,   // [1:0] status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     error_count,
   output int                     pending_words,
   output int                     held_count
);

   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);

   typedef struct {
      status_type  status;
      logic [31:0] item;
      logic [6:0]  count;
   } reply_t;

   // Shadow copy of the array, its count and the capacity register
   logic [OAIR_ELEM_W-1:0] slots [OAIR_DEPTH];
   int                     slot_count;
   logic [6:0]             cap_limit;

   reply_t expected_replies [$];
   int     mismatches;

   initial begin
      error_count   = 0;
      pending_words = 0;
      held_count    = 0;
      mismatches    = 0;
      slot_count    = 0;
      cap_limit     = CAPACITY_RESET;
   end

   // Apply one request to the shadow array and return the response it gives
   function automatic reply_t apply_array_op(kind_type kind, logic [6:0] pos,
                                             logic [31:0] val);
      reply_t r;
      int     eff_limit;
      int     at;
      r.status  = STAT_OK;
      r.item    = '0;
      eff_limit = (int'(cap_limit) > OAIR_DEPTH) ? OAIR_DEPTH : int'(cap_limit);
      case (kind)
         KIND_APPEND, KIND_INSERT: begin
            at = (kind == KIND_APPEND) ? slot_count : int'(pos);
            // full is checked ahead of the position
            if (slot_count >= eff_limit) begin
               r.status = STAT_FULL;
            end else if (at > slot_count) begin
               r.status = STAT_RANGE;
            end else begin
               for (int i = slot_count; i > at; i--) slots[i] = slots[i-1];
               slots[at] = val;
               slot_count++;
            end
         end
         KIND_POP: begin
            if (slot_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               slot_count--;
               r.item = slots[slot_count];
            end
         end
         default: begin
            // remove at position; an empty array reports out of range
            if (int'(pos) >= slot_count) begin
               r.status = STAT_RANGE;
            end else begin
               r.item = slots[pos];
               for (int i = int'(pos); i + 1 < slot_count; i++) slots[i] = slots[i+1];
               slot_count--;
            end
         end
      endcase
      r.count = 7'(slot_count);
      return r;
   endfunction

   always @(posedge clock) begin
      reply_t want;
      if (reset) begin
         slot_count = 0;
         cap_limit  = CAPACITY_RESET;
         expected_replies.delete();
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CAP_ADDR)
            cap_limit = csr_pwdata[6:0];

         // response word: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: response word with none expected: status %0d item %h count %0d",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[31:0] !== want.item) begin
                  $display("%0t: item_out mismatch, expected %h, actual %h",
                           $time, want.item, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[38:32] !== want.count) begin
                  $display("%0t: count_after mismatch, expected %0d, actual %0d",
                           $time, want.count, rsp_tdata[38:32]);
                  mismatches++;
               end
            end
         end

         // request word: predict its response
         if (req_tvalid && req_tready)
            expected_replies.push_back(apply_array_op(kind_type'(req_tuser),
                                                      req_tdata[6:0], req_tdata[38:7]));
      end
      error_count   <= mismatches;
      pending_words <= expected_replies.size();
      held_count    <= slot_count;
   end

endmodule

// ===== bench/ordered_array_insert_remove_unit_tb.sv =====
// Testbench top for the ordered array insert/remove unit: clock, reset,
// request stimulus, register writes, response back-pressure and the verdict.
// Depends on oair_pkg, the unit itself and ordered_array_insert_remove_unit_checker.
`timescale 1ns / 100ps

module ordered_array_insert_remove_unit_tb;
   import oair_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [6:0] position, [38:7] item_value
   logic [1:0]             req_tuser = '0;   // [1:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [31:0] item_out, [38:32] count_after
   logic [1:0]             rsp_tuser;        // [1:0] status
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int error_count;
   int pending_words;
   int held_count;
   int cycle_count = 0;
   bit stall_on = 1'b1;
   int run_left = 0;

   ordered_array_insert_remove_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ordered_array_insert_remove_unit_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_words (pending_words),
      .held_count    (held_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** ordered_array_insert_remove_unit: FAILED **");
         $finish;
      end
   end

   // Response back-pressure: alternating ready and stall runs of random length, or always ready when stall_on is clear
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_tready <= 1'b1;
         run_left   <= 0;
      end else if (run_left == 0) begin
         rsp_tready <= !rsp_tready;
         run_left   <= rsp_tready ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end else begin
         run_left <= run_left - 1;
      end
   end

   // Present one request word and hold it until accepted; valid stays high
   task automatic send_word(input kind_type kind, input int pos, input logic [31:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, val, 7'(pos)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted response has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] cap);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Random traffic under one capacity setting; the fill level is steered
   // toward a moving target so the array sweeps from empty to full
   task automatic run_phase(input logic [6:0] cap, input int n_items,
                            input bit gaps_on, input bit stall);
      int          sent;
      int          burst;
      int          target;
      int          held;
      int          pos;
      bit          grow;
      kind_type    kind;
      logic [31:0] val;
      write_capacity(cap);
      stall_on <= stall;
      sent   = 0;
      target = $urandom_range(0, OAIR_DEPTH);
      while (sent < n_items) begin
         burst = $urandom_range(1, 20);
         if (gaps_on) begin
            if ($urandom_range(0, 39) == 0) drain_results();
            else pause_sender($urandom_range(0, 6));
         end
         repeat (burst) begin
            if (sent % 48 == 0) target = $urandom_range(0, OAIR_DEPTH);
            held = held_count;
            grow = (held < target) ? ($urandom_range(0, 99) < 80)
                                   : ($urandom_range(0, 99) < 20);
            if (grow) kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
            else kind = $urandom_range(0, 1) ? KIND_REMOVE : KIND_POP;
            if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 127);
            else if (kind == KIND_REMOVE && held > 0) pos = $urandom_range(0, held - 1);
            else pos = $urandom_range(0, held);
            case ($urandom_range(0, 9))
               0: val = '0;
               1: val = '1;
               default: val = $urandom;
            endcase
            send_word(kind, pos, val);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty array, insert/remove positions at and past the count
      send_word(KIND_POP, 0, '0);
      send_word(KIND_REMOVE, 0, '1);
      send_word(KIND_INSERT, 1, 32'h1234_5678);
      send_word(KIND_INSERT, 0, 32'hFFFF_FFFF);
      send_word(KIND_APPEND, 127, 32'h0000_0000);
      send_word(KIND_INSERT, 2, 32'hA5A5_A5A5);
      send_word(KIND_INSERT, 127, 32'hDEAD_BEEF);
      send_word(KIND_INSERT, 1, 32'h5A5A_5A5A);
      send_word(KIND_REMOVE, 3, '0);
      send_word(KIND_REMOVE, 0, '0);
      send_word(KIND_REMOVE, 2, '0);
      send_word(KIND_POP, 0, '0);
      send_word(KIND_POP, 0, '0);

      // Limit of one: full check ahead of the position check
      write_capacity(7'd1);
      send_word(KIND_APPEND, 0, 32'h8000_0001);
      send_word(KIND_APPEND, 0, 32'h0000_0002);
      send_word(KIND_INSERT, 5, 32'h0000_0003);
      send_word(KIND_REMOVE, 0, '0);

      // Limit of zero: every add reports full
      write_capacity(7'd0);
      send_word(KIND_APPEND, 0, 32'h0000_0004);
      send_word(KIND_INSERT, 0, 32'h0000_0005);

      // Limit lowered below the count: adds refused, removes still work
      write_capacity(7'd64);
      send_word(KIND_APPEND, 0, 32'h1111_1111);
      send_word(KIND_APPEND, 0, 32'h2222_2222);
      send_word(KIND_APPEND, 0, 32'h3333_3333);
      write_capacity(7'd2);
      send_word(KIND_APPEND, 0, 32'h4444_4444);
      send_word(KIND_POP, 0, '0);
      send_word(KIND_POP, 0, '0);
      send_word(KIND_POP, 0, '0);

      // Random phases over several limits, including ones above the depth
      run_phase(7'd64, 200, 1'b1, 1'b1);
      run_phase(7'd127, 200, 1'b1, 1'b1);
      run_phase(7'd1, 150, 1'b1, 1'b1);
      run_phase(7'($urandom_range(3, 63)), 200, 1'b1, 1'b1);
      run_phase(7'd0, 100, 1'b1, 1'b1);
      run_phase(7'd100, 200, 1'b0, 1'b0);
      run_phase(7'd2, 150, 1'b1, 1'b1);
      run_phase(7'($urandom_range(1, 64)), 200, 1'b1, 1'b0);
      run_phase(7'd64, 250, 1'b1, 1'b1);
      run_phase(7'd127, 300, 1'b0, 1'b1);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_words == 0) begin
         $display("** ordered_array_insert_remove_unit: PASSED **");
      end else begin
         $display("** ordered_array_insert_remove_unit: FAILED **");
      end
      $finish;
   end

endmodule
